[hdl/bba_pkg.sv]
`timescale 1ns / 1ps
package bba_pkg;
    localparam int WORD_BITS = 64;

    typedef enum logic [1:0] {
        CMD_ALLOC     = 2'd0,
        CMD_FREE      = 2'd1,
        CMD_MARK_USED = 2'd2,
        CMD_MARK_FREE = 2'd3
    } cmd_t;

    localparam logic CFG_MEM_BASE     = 1'b0;
    localparam logic CFG_TOTAL_BLOCKS = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CLEAR  = 7'b0000010,
        ST_SREAD  = 7'b0000100,
        ST_SCAN   = 7'b0001000,
        ST_MREAD  = 7'b0010000,
        ST_MWRITE = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;
endpackage

[hdl/bba_ram.sv]
`timescale 1ns / 1ps
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hdl/bitmap_block_allocator_unit.sv]
`timescale 1ns / 1ps
// Bitmap block allocator. One command per start pulse while busy is low;
// exactly one result follows, shown for one cycle with done high (the
// receiver cannot stall). The used map lives in a RAM of 64-bit words with
// registered reads. After reset the map is cleared one word a cycle, all
// MAX_BLOCKS/64 words (1024 by default), with busy high. Allocation scans
// one bit per cycle from the hint, with an extra read state (ST_SREAD) for
// every map word entered, then marks the run with a read and a write per
// touched word. Free and mark commands read, modify and write each touched
// map word. Configuration writes are always accepted (cfg_ready tied high);
// write them only idle.
module bitmap_block_allocator_unit
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS  = 65536,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [47:0] addr,
    input  logic [28:0] amount,
    output logic        done,
    output logic        ok,
    output logic [47:0] alloc_addr,
    output logic [16:0] used_blocks,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [47:0] cfg_data
);
    localparam int BW    = $clog2(MAX_BLOCKS) + 1; // block index incl. MAX
    localparam int WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SH    = $clog2(BLOCK_BYTES);
    localparam int LW    = 49;
    localparam logic [16:0] CAP = (MAX_BLOCKS < 131071) ? 17'(MAX_BLOCKS) : 17'h1FFFF;

    state_t             state_reg, state_next;
    logic [47:0]        mem_base_reg;
    logic [16:0]        total_reg;
    logic [BW-1:0]      hint_reg, hint_next;
    logic [16:0]        count_reg, count_next;
    logic [LW-1:0]      cur_reg, cur_next;     // current block index
    logic [LW-1:0]      end_reg, end_next;     // exclusive end, clamped
    logic [LW-1:0]      start_reg, start_next; // run start during scan
    logic [28:0]        run_reg, run_next;
    logic [28:0]        amt_reg;
    logic               used_reg;              // marking sets bits
    logic               alloc_reg;
    logic               ok_reg, ok_next;
    logic [47:0]        aaddr_reg, aaddr_next;
    logic [LW-1:0]      n_reg, n_next;
    logic [AW-1:0]      clr_reg;
    logic               done_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

    bba_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_map (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    logic [BW-1:0] lim;
    assign lim = (32'(total_reg) > 32'(MAX_BLOCKS)) ? BW'(MAX_BLOCKS) : BW'(total_reg);

    // command decode
    logic [47:0]   off;
    logic [LW-1:0] blk_up, blk_dn, len_up, len_dn, first_c, len_c, endraw, endcl;
    assign off    = addr - mem_base_reg;
    assign blk_dn = LW'(off >> SH);
    assign blk_up = LW'(({1'b0, off} + 49'(BLOCK_BYTES - 1)) >> SH);
    assign len_up = LW'((30'(amount) + 30'(BLOCK_BYTES - 1)) >> SH);
    assign len_dn = LW'(amount >> SH);
    always_comb
    begin
        unique case (cmd_t'(cmd))
            CMD_FREE:      begin first_c = blk_up; len_c = LW'(amount); end
            CMD_MARK_USED: begin first_c = blk_dn; len_c = len_up; end
            CMD_MARK_FREE: begin first_c = blk_up; len_c = len_dn; end
            default:       begin first_c = LW'(hint_reg); len_c = LW'(amount); end
        endcase
    end
    assign endraw = first_c + len_c;
    assign endcl  = (endraw > LW'(lim)) ? LW'(lim) : endraw;

    // word mask for the marking span within the current word
    logic [LW-1:0]        wbase, wend;
    logic [WORD_BITS-1:0] span;
    logic [5:0]           bpos;
    assign bpos  = cur_reg[5:0];
    assign wbase = {cur_reg[LW-1:6], 6'd0};
    assign wend  = (end_reg < wbase + LW'(WORD_BITS)) ? end_reg : wbase + LW'(WORD_BITS);
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            span[i] = (LW'(i) >= LW'(bpos)) && (wbase + LW'(i) < wend);
        end
    end

    logic [LW-1:0] span_n;
    assign span_n = wend - cur_reg;

    logic [17:0] cnt_add;
    assign cnt_add = 18'(count_reg) + 18'(n_reg > LW'(CAP) ? LW'(CAP) : n_reg);

    always_comb
    begin
        state_next = state_reg;
        hint_next  = hint_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        end_next   = end_reg;
        start_next = start_reg;
        run_next   = run_reg;
        ok_next    = ok_reg;
        aaddr_next = aaddr_reg;
        n_next     = n_reg;
        ram_we     = 1'b0;
        ram_waddr  = cur_reg[AW+5:6];
        ram_wdata  = used_reg ? (ram_rdata | span) : (ram_rdata & ~span);
        ram_raddr  = cur_reg[AW+5:6];
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == AW'(WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    ok_next    = 1'b1;
                    aaddr_next = '0;
                    n_next     = '0;
                    if (cmd_t'(cmd) == CMD_ALLOC)
                    begin
                        cur_next   = LW'(hint_reg);
                        start_next = LW'(hint_reg);
                        run_next   = '0;
                        end_next   = LW'(lim);
                        if (amount == '0 || hint_reg >= lim)
                        begin
                            ok_next    = 1'b0;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_SREAD;
                        end
                    end
                    else
                    begin
                        if (cmd_t'(cmd) != CMD_MARK_USED && first_c < LW'(hint_reg))
                        begin
                            hint_next = BW'(first_c);
                        end
                        cur_next = first_c;
                        end_next = endcl;
                        state_next = (first_c < endcl) ? ST_MREAD : ST_DONE;
                    end
                end
            end
            ST_SREAD:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // one bit per cycle; the word is re-read at word boundaries
                if (ram_rdata[bpos])
                begin
                    run_next   = '0;
                    start_next = cur_reg + 1'b1;
                end
                else
                begin
                    run_next = run_reg + 1'b1;
                end
                cur_next = cur_reg + 1'b1;
                if (!ram_rdata[bpos] && run_reg + 1'b1 >= amt_reg)
                begin
                    ok_next    = 1'b1;
                    aaddr_next = mem_base_reg + 48'(start_reg << SH);
                    if (amt_reg == 29'd1)
                    begin
                        hint_next = BW'(start_reg + 1'b1);
                    end
                    cur_next   = start_reg;
                    end_next   = start_reg + LW'(amt_reg);
                    state_next = ST_MREAD;
                end
                else if (cur_reg + 1'b1 >= LW'(lim))
                begin
                    ok_next    = 1'b0;
                    state_next = ST_DONE;
                end
                else if (bpos == 6'd63)
                begin
                    ram_raddr  = cur_next[AW+5:6];
                    state_next = ST_SREAD;
                end
            end
            ST_MREAD:
            begin
                state_next = ST_MWRITE;
            end
            ST_MWRITE:
            begin
                ram_we   = 1'b1;
                n_next   = n_reg + span_n;
                cur_next = wend;
                state_next = (wend >= end_reg) ? ST_DONE : ST_MREAD;
            end
            ST_DONE:
            begin
                if (used_reg)
                begin
                    count_next = (cnt_add > 18'(CAP)) ? CAP : cnt_add[16:0];
                end
                else
                begin
                    count_next = (n_reg > LW'(count_reg)) ? 17'd0 : count_reg - 17'(n_reg);
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            mem_base_reg <= '0;
            total_reg    <= '0;
            hint_reg     <= '0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hint_reg  <= hint_next;
            count_reg <= count_next;
            done_reg  <= (state_reg == ST_DONE);
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_valid)
            begin
                if (cfg_index == CFG_MEM_BASE)
                begin
                    mem_base_reg <= cfg_data;
                end
                else
                begin
                    total_reg <= cfg_data[16:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        end_reg   <= end_next;
        start_reg <= start_next;
        run_reg   <= run_next;
        ok_reg    <= ok_next;
        aaddr_reg <= aaddr_next;
        n_reg     <= n_next;
        if (state_reg == ST_IDLE && start)
        begin
            amt_reg   <= amount;
            used_reg  <= (cmd_t'(cmd) == CMD_ALLOC) || (cmd_t'(cmd) == CMD_MARK_USED);
            alloc_reg <= (cmd_t'(cmd) == CMD_ALLOC);
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign done        = done_reg;
    assign ok          = ok_reg;
    assign alloc_addr  = aaddr_reg;
    assign used_blocks = count_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    a_fail_noaddr: assert property (@(posedge clk) disable iff (!rst_n)
        done && !ok |-> alloc_addr == '0) else $error("failed alloc has address");
    a_fail_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        done && !ok |-> alloc_reg) else $error("non-alloc failed");
endmodule

[tb/sv/tb_bitmap_block_allocator_unit.sv]
`timescale 1ns / 1ps
module tb_bitmap_block_allocator_unit;
    import bba_pkg::*;

    localparam int MAX_BLOCKS  = 65536;
    localparam int BLOCK_BYTES = 4096;
    localparam longint unsigned MASK48    = 48'hFFFF_FFFF_FFFF;
    localparam int              STALL_MAX = 300000;

    // Expected result of one request.
    typedef struct packed {
        logic        ok;
        logic [47:0] alloc_addr;
        logic [16:0] used_blocks;
    } alloc_result_t;

    // Scoreboard: private copy of the allocator state plus the queue of
    // results still owed by the block.
    class alloc_scoreboard;
        bit                used_map [MAX_BLOCKS];
        longint unsigned   hint;
        longint unsigned   used_cnt;
        longint unsigned   base;
        longint unsigned   total;
        alloc_result_t     pending [$];
        int                mismatches;
        int                stray;
        int                checked;

        function new();
            foreach (used_map[i]) used_map[i] = 1'b0;
            hint = 0;
            used_cnt = 0;
            base = 0;
            total = 0;
            mismatches = 0;
            stray = 0;
            checked = 0;
        endfunction

        function void set_reg(logic idx, logic [47:0] data);
            if (idx == CFG_MEM_BASE)
                base = data;
            else
                total = data[16:0];
        endfunction

        function longint unsigned managed();
            return (total < MAX_BLOCKS) ? total : MAX_BLOCKS;
        endfunction

        // Set or clear a block range, clipped to the managed area.
        function void apply_range(longint unsigned first, longint unsigned len, bit mark);
            longint unsigned lim;
            longint unsigned stop;
            longint unsigned n;
            lim = managed();
            stop = first + len;
            n = 0;
            if (!mark && first < hint)
                hint = first;
            if (stop > lim)
                stop = lim;
            for (longint unsigned b = first; b < stop; b++)
            begin
                used_map[b] = mark;
                n++;
            end
            if (mark)
                used_cnt = (used_cnt + n > MAX_BLOCKS) ? MAX_BLOCKS : used_cnt + n;
            else
                used_cnt = (n > used_cnt) ? 0 : used_cnt - n;
        endfunction

        function void note_request(cmd_t c, logic [47:0] a, logic [28:0] n);
            alloc_result_t   r;
            longint unsigned ofs;
            longint unsigned lim;
            longint unsigned run_start;
            longint unsigned run_len;
            bit              found;
            ofs = (longint'(a) - base) & MASK48;
            r.ok = 1'b1;
            r.alloc_addr = '0;
            case (c)
                CMD_ALLOC:
                begin
                    lim = managed();
                    run_start = hint;
                    run_len = 0;
                    found = 1'b0;
                    r.ok = 1'b0;
                    if (n != 0)
                    begin
                        for (longint unsigned b = hint; b < lim; b++)
                        begin
                            if (used_map[b])
                            begin
                                run_len = 0;
                                run_start = b + 1;
                            end
                            else
                            begin
                                run_len++;
                                if (run_len >= n)
                                begin
                                    found = 1'b1;
                                    break;
                                end
                            end
                        end
                    end
                    if (found)
                    begin
                        if (n == 1)
                            hint = run_start + 1;
                        apply_range(run_start, n, 1'b1);
                        r.ok = 1'b1;
                        r.alloc_addr = 48'((base + run_start * BLOCK_BYTES) & MASK48);
                    end
                end
                CMD_FREE:
                    apply_range((ofs + BLOCK_BYTES - 1) / BLOCK_BYTES, n, 1'b0);
                CMD_MARK_USED:
                    apply_range(ofs / BLOCK_BYTES, (longint'(n) + BLOCK_BYTES - 1) / BLOCK_BYTES,
                                1'b1);
                default:
                    apply_range((ofs + BLOCK_BYTES - 1) / BLOCK_BYTES, n / BLOCK_BYTES, 1'b0);
            endcase
            r.used_blocks = used_cnt[16:0];
            pending.push_back(r);
        endfunction

        function void check_result(logic o, logic [47:0] a, logic [16:0] u);
            alloc_result_t e;
            checked++;
            if (pending.size() == 0)
            begin
                stray++;
                $display("error: result with nothing pending (ok=%0d addr=%h used=%0d)",
                         o, a, u);
                return;
            end
            e = pending.pop_front();
            if (o !== e.ok || a !== e.alloc_addr || u !== e.used_blocks)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp ok=%0d addr=%h used=%0d, got ok=%0d addr=%h used=%0d",
                             e.ok, e.alloc_addr, e.used_blocks, o, a, u);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic [47:0] addr;
    logic [28:0] amount;
    logic        done;
    logic        ok;
    logic [47:0] alloc_addr;
    logic [16:0] used_blocks;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [47:0] cfg_data;

    alloc_scoreboard sb;
    bit              idle_on;      // random gaps allowed on the request side
    int              stall_cycles; // cycles since anything was accepted
    int              sent;
    int              cmd_seen [4];

    bitmap_block_allocator_unit #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .addr        (addr),
        .amount      (amount),
        .done        (done),
        .ok          (ok),
        .alloc_addr  (alloc_addr),
        .used_blocks (used_blocks),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Result monitor and watchdog. Outputs are read right after the edge,
    // before the block's nonblocking updates land, so they are the values
    // that the edge captured.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(ok, alloc_addr, used_blocks);
            if (done || (start && !busy) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_MAX)
            begin
                $display("timeout: no progress for %0d cycles", STALL_MAX);
                $display("FAIL bitmap_block_allocator_unit");
                $finish;
            end
        end
    end

    // One request: optional random gap, then hold start until busy is low at
    // an edge. start stays high on exit so a back-to-back request does not
    // drop and reraise it in one step.
    task automatic send_request(cmd_t c, logic [47:0] a, logic [28:0] n);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        cmd    <= c;
        addr   <= a;
        amount <= n;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(c, a, n);
        sent++;
        cmd_seen[c]++;
    endtask

    // Lower start and wait until every owed result has come back.
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending.size() != 0 || busy);
    endtask

    // Register write, only from idle.
    task automatic write_reg(logic idx, logic [47:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    // Random request aimed mostly at the managed window.
    task automatic random_request();
        cmd_t            c;
        logic [47:0]     a;
        logic [28:0]     n;
        longint unsigned span;
        c = cmd_t'($urandom_range(0, 3));
        span = sb.managed() * BLOCK_BYTES;
        if ($urandom_range(0, 9) < 8)
            a = 48'(sb.base + $urandom_range(0, int'(span) + 2 * BLOCK_BYTES)
                    - $urandom_range(0, 8));
        else
            a = rand48();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: n = (c inside {CMD_ALLOC, CMD_FREE})
                                  ? 29'($urandom_range(0, 8))
                                  : 29'($urandom_range(0, 8 * BLOCK_BYTES));
            6, 7, 8: n = (c inside {CMD_ALLOC, CMD_FREE})
                         ? 29'($urandom_range(0, int'(sb.managed()) + 2))
                         : 29'($urandom_range(0, int'(span) + BLOCK_BYTES));
            default: n = 29'($urandom);
        endcase
        send_request(c, a, n);
    endtask

    task automatic random_phase(logic [47:0] base, logic [16:0] blocks, int count);
        write_reg(CFG_MEM_BASE, base);
        write_reg(CFG_TOTAL_BLOCKS, 48'(blocks));
        repeat (count) random_request();
    endtask

    initial
    begin
        sb = new();
        idle_on = 1'b1;
        stall_cycles = 0;
        sent = 0;
        foreach (cmd_seen[i]) cmd_seen[i] = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_ALLOC;
        addr = '0;
        amount = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MEM_BASE;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset config: nothing managed, so allocation must fail.
        send_request(CMD_ALLOC, '0, 29'd1);
        send_request(CMD_MARK_USED, '0, 29'd4096);

        // Directed part: 64 blocks at base 0x1000_0000.
        write_reg(CFG_MEM_BASE, 48'h0000_1000_0000);
        write_reg(CFG_TOTAL_BLOCKS, 48'd64);
        send_request(CMD_ALLOC, '0, 29'd0);                    // zero blocks fails
        send_request(CMD_ALLOC, rand48(), 29'd1);              // single block, hint moves
        send_request(CMD_ALLOC, '0, 29'd3);                    // multi block
        send_request(CMD_ALLOC, '0, 29'd100);                  // no run long enough
        send_request(CMD_FREE, 48'h0000_0FFF_F000, 29'd4);     // below base: no change
        send_request(CMD_FREE, 48'h0000_1000_0001, 29'd0);     // round up, zero length
        send_request(CMD_FREE, 48'h0000_1000_0000, 29'd1);     // free lowers hint
        send_request(CMD_MARK_USED, 48'h0000_1000_1FFF, 29'd1);// round down / up
        send_request(CMD_MARK_USED, 48'h0000_1000_0000, 29'h1000_0000); // fill, clip
        send_request(CMD_MARK_USED, 48'h0000_1000_0000, 29'd8192); // saturate-side recount
        send_request(CMD_ALLOC, '0, 29'd1);                    // full map fails
        send_request(CMD_MARK_FREE, 48'h0000_1000_0800, 29'd12287); // round base up, len down
        send_request(CMD_MARK_FREE, 48'hFFFF_FFFF_FFFF, 29'h1FFF_FFFF);
        send_request(CMD_FREE, 48'h0000_1000_0000, 29'h1FFF_FFFF); // free all 64 blocks, count stays above 0
        send_request(CMD_FREE, 48'h0000_1000_0000, 29'd5);     // count floors at 0
        send_request(CMD_ALLOC, '0, 29'd64);                   // whole area
        send_request(CMD_FREE, 48'h0000_1000_0000, 29'd64);
        send_request(CMD_ALLOC, '0, 29'd2);

        // Hint beyond a shrunk area: allocation must fail.
        send_request(CMD_MARK_USED, 48'h0000_1000_0000, 29'd40960);
        send_request(CMD_ALLOC, '0, 29'd1);
        write_reg(CFG_TOTAL_BLOCKS, 48'd4);
        send_request(CMD_ALLOC, '0, 29'd1);

        // Random phases over several settings, including a base near the top
        // of the address space so result addresses wrap.
        random_phase(rand48(), 17'd200, 110);
        // Pressure: stop and let every result come back mid-phase.
        drain();
        repeat (60) random_request();
        random_phase(48'hFFFF_FFFF_F000, 17'd96, 90);
        random_phase(rand48(), 17'd1000, 70);
        random_phase(48'h0, 17'd1, 50);
        random_phase(rand48(), 17'd0, 20);

        // Full-size area: a handful of requests, one failing full scan.
        write_reg(CFG_MEM_BASE, 48'h0);
        write_reg(CFG_TOTAL_BLOCKS, 48'd65536);
        send_request(CMD_ALLOC, '0, 29'd1);
        send_request(CMD_ALLOC, '0, 29'd16);
        send_request(CMD_MARK_USED, 48'h0, 29'h1000_0000);
        send_request(CMD_ALLOC, '0, 29'd1);
        send_request(CMD_MARK_FREE, 48'h0, 29'h1000_0000);
        send_request(CMD_ALLOC, '0, 29'd4096);
        send_request(CMD_FREE, 48'h0, 29'd4096);

        // Last part: no idling at all, back-to-back requests.
        idle_on = 1'b0;
        random_phase(rand48(), 17'd128, 100);

        drain();
        repeat (100) @(posedge clk);

        $display("covered %0d requests (alloc %0d, free %0d, mark used %0d, mark free %0d)",
                 sent, cmd_seen[CMD_ALLOC], cmd_seen[CMD_FREE],
                 cmd_seen[CMD_MARK_USED], cmd_seen[CMD_MARK_FREE]);
        $display("area sizes 0 to 65536 blocks, %0d results checked, %0d mismatches",
                 sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.stray == 0 && sb.pending.size() == 0)
            $display("PASS bitmap_block_allocator_unit");
        else
            $display("FAIL bitmap_block_allocator_unit");
        $finish;
    end
endmodule
